/* hw/rtl/hvn_pkg.sv */
// Shared types and constants for the heightmap vertex and normal unit.
package hvn_pkg;

    // Field widths
    localparam int IDX_W      = 10;
    localparam int PIX_W      = 24;
    localparam int GP_W       = 11;
    localparam int EXT_W      = 16;
    localparam int MH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_EXTENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 2'd2;

    // Register reset values
    localparam logic [GP_W-1:0]  GP_RESET  = 11'd300;
    localparam logic [EXT_W-1:0] EXT_RESET = 16'd1600;
    localparam logic [MH_W-1:0]  MH_RESET  = 8'd100;

    // Pixel slots: center and the four neighbors
    localparam int PIX_N   = 5;
    localparam int PIX_CTR = 0;
    localparam int PIX_PR  = 1;
    localparam int PIX_NR  = 2;
    localparam int PIX_PC  = 3;
    localparam int PIX_NC  = 4;

    // Result widths
    localparam int POS_W  = 24;
    localparam int POSY_W = 16;
    localparam int TEX_W  = 17;
    localparam int NRM_W  = 16;
    localparam int NRMY_W = 15;
    localparam logic [POS_W-1:0] POS_MAX = 24'hFFFF00;

    // Height and normal arithmetic
    localparam int RAW_W    = 32;          // R*G*B*peak height
    localparam int SLOPE_W  = 24;          // Q.16 height magnitude
    localparam int SQ_W     = 2 * SLOPE_W; // one squared slope
    localparam int SUM_W    = 50;          // sum of three squares
    localparam logic [SUM_W-1:0] Y_SQ = 50'h4_0000_0000; // (2<<16)^2
    localparam int RAD_W    = 64;          // radicand width
    localparam int LEN_W    = RAD_W / 2;   // root width
    localparam int NUM_W    = 45;          // component << 20 plus half length
    localparam logic [NUM_W-1:0] Y_NUM = 45'h20_0000_0000; // (2<<16) << 20
    localparam int NQ_W     = 14;          // quotient bits below one in Q2.14

    // Pipeline latencies
    localparam int HGT_LAT  = 4;
    localparam int SQRT_LAT = LEN_W;
    localparam int NRM_LAT  = 2 + SQRT_LAT + 1 + (NQ_W + 1) + 1;

    // Slope handed from the height stages to the normal stages
    typedef struct packed {
        logic               neg_x;
        logic               neg_z;
        logic [SLOPE_W-1:0] mag_x;
        logic [SLOPE_W-1:0] mag_z;
    } t_slope;

endpackage

/* hw/rtl/heightmap_vertex_and_normal_unit.sv */
// Heightmap vertex and normal unit: one grid point in, one terrain vertex out.
// Pipeline depth is set mostly by the 32-stage square root and 15-stage normal divider.
// Throughput: one point per cycle; a stalled result freezes the whole pipeline.
// Reset: valid bits clear and the registers return to 300, 1600 and 100.
// No memories, so no clearing pass after reset.
module heightmap_vertex_and_normal_unit #(
    parameter int MAX_GRID = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hvn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // grid point in
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [hvn_pkg::IDX_W-1:0]          i_row,
    input  logic [hvn_pkg::IDX_W-1:0]          i_col,
    input  logic [hvn_pkg::PIX_W-1:0]          i_center_pixel,
    input  logic [hvn_pkg::PIX_W-1:0]          i_prev_row_pixel,
    input  logic [hvn_pkg::PIX_W-1:0]          i_next_row_pixel,
    input  logic [hvn_pkg::PIX_W-1:0]          i_prev_col_pixel,
    input  logic [hvn_pkg::PIX_W-1:0]          i_next_col_pixel,
    // vertex out
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [hvn_pkg::POS_W-1:0]          o_pos_x,
    output logic [hvn_pkg::POSY_W-1:0]         o_pos_y,
    output logic [hvn_pkg::POS_W-1:0]          o_pos_z,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_normal_x,
    output logic [hvn_pkg::NRMY_W-1:0]         o_normal_y,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_normal_z,
    output logic [hvn_pkg::TEX_W-1:0]          o_tex_u,
    output logic [hvn_pkg::TEX_W-1:0]          o_tex_v
);

    localparam int GW       = $clog2(MAX_GRID + 1);
    localparam int DENW     = $clog2(MAX_GRID);
    localparam int L_TOT    = hvn_pkg::HGT_LAT + hvn_pkg::NRM_LAT;
    localparam int CPROD_W  = hvn_pkg::IDX_W + hvn_pkg::EXT_W;
    localparam int POSN_W   = CPROD_W + 9;
    localparam int TEXN_W   = hvn_pkg::IDX_W + 17;
    localparam int POS_QW   = hvn_pkg::POS_W;
    localparam int TEX_QW   = hvn_pkg::TEX_W - 1;
    localparam int POS_DLY  = L_TOT - (2 + POS_QW + 1);
    localparam int TEX_DLY  = L_TOT - (2 + TEX_QW + 1);
    localparam int POSY_DLY = L_TOT - hvn_pkg::HGT_LAT;

    logic [hvn_pkg::GP_W-1:0]  r_grid_points;
    logic [hvn_pkg::EXT_W-1:0] r_grid_extent;
    logic [hvn_pkg::MH_W-1:0]  r_peak_height;
    logic [GW-1:0]             w_geff;
    logic [DENW-1:0]           w_den;
    logic [L_TOT:1]            r_vld;
    logic                      w_en;
    logic [hvn_pkg::PIX_W-1:0] w_pix [hvn_pkg::PIX_N];

    logic [hvn_pkg::POSY_W-1:0] w_posy;
    hvn_pkg::t_slope            w_slope;

    logic [CPROD_W-1:0]        r_c1_cprod, r_c1_rprod;
    logic [hvn_pkg::IDX_W-1:0] r_c1_col, r_c1_row;
    logic [POSN_W-1:0]         r_c2_xnum, r_c2_znum;
    logic [TEXN_W-1:0]         r_c2_unum, r_c2_vnum;
    logic [POS_QW:0]           w_qx, w_qz;
    logic [TEX_QW:0]           w_qu, w_qv;

    logic [hvn_pkg::POS_W-1:0]  r_px_d [0:POS_DLY-1];
    logic [hvn_pkg::POS_W-1:0]  r_pz_d [0:POS_DLY-1];
    logic [hvn_pkg::TEX_W-1:0]  r_tu_d [0:TEX_DLY-1];
    logic [hvn_pkg::TEX_W-1:0]  r_tv_d [0:TEX_DLY-1];
    logic [hvn_pkg::POSY_W-1:0] r_py_d [0:POSY_DLY-1];

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_points <= hvn_pkg::GP_RESET;
            r_grid_extent <= hvn_pkg::EXT_RESET;
            r_peak_height <= hvn_pkg::MH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hvn_pkg::CFG_GRID_POINTS: r_grid_points <= i_cfg_data[hvn_pkg::GP_W-1:0];
                hvn_pkg::CFG_GRID_EXTENT: r_grid_extent <= i_cfg_data[hvn_pkg::EXT_W-1:0];
                hvn_pkg::CFG_MAX_HEIGHT:  r_peak_height <= i_cfg_data[hvn_pkg::MH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective grid size clamped to [2, MAX_GRID]
    always_comb begin
        if (r_grid_points < hvn_pkg::GP_W'(2)) begin
            w_geff = GW'(2);
        end else if (int'(r_grid_points) > MAX_GRID) begin
            w_geff = GW'(MAX_GRID);
        end else begin
            w_geff = GW'(r_grid_points);
        end
        w_den = DENW'(w_geff - GW'(1));
    end

    // Pipeline advances unless a finished vertex is held
    assign o_stall = r_vld[L_TOT] & i_stall;
    assign w_en    = ~o_stall;
    assign o_valid = r_vld[L_TOT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L_TOT-1:1], i_valid};
        end
    end

    assign w_pix[hvn_pkg::PIX_CTR] = i_center_pixel;
    assign w_pix[hvn_pkg::PIX_PR]  = i_prev_row_pixel;
    assign w_pix[hvn_pkg::PIX_NR]  = i_next_row_pixel;
    assign w_pix[hvn_pkg::PIX_PC]  = i_prev_col_pixel;
    assign w_pix[hvn_pkg::PIX_NC]  = i_next_col_pixel;

    hvn_height #(.GW(GW)) u_height (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_geff        (w_geff),
        .i_peak_height (r_peak_height),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_pix         (w_pix),
        .o_pos_y       (w_posy),
        .o_slope       (w_slope)
    );

    hvn_normal u_normal (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_slope    (w_slope),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y),
        .o_normal_z (o_normal_z)
    );

    // Coordinates: index times extent, then rounded division by grid size - 1
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_cprod <= CPROD_W'(i_col) * CPROD_W'(r_grid_extent);
            r_c1_rprod <= CPROD_W'(i_row) * CPROD_W'(r_grid_extent);
            r_c1_col   <= i_col;
            r_c1_row   <= i_row;
            r_c2_xnum  <= POSN_W'({r_c1_cprod, 8'b0}) + POSN_W'(w_den >> 1);
            r_c2_znum  <= POSN_W'({r_c1_rprod, 8'b0}) + POSN_W'(w_den >> 1);
            r_c2_unum  <= TEXN_W'({r_c1_col, 16'b0}) + TEXN_W'(w_den >> 1);
            r_c2_vnum  <= TEXN_W'({r_c1_row, 16'b0}) + TEXN_W'(w_den >> 1);
        end
    end

    hvn_div #(.NW(POSN_W), .DW(DENW), .QW(POS_QW)) u_div_px (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_c2_xnum), .i_den (w_den), .o_quo (w_qx)
    );

    hvn_div #(.NW(POSN_W), .DW(DENW), .QW(POS_QW)) u_div_pz (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_c2_znum), .i_den (w_den), .o_quo (w_qz)
    );

    hvn_div #(.NW(TEXN_W), .DW(DENW), .QW(TEX_QW)) u_div_tu (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_c2_unum), .i_den (w_den), .o_quo (w_qu)
    );

    hvn_div #(.NW(TEXN_W), .DW(DENW), .QW(TEX_QW)) u_div_tv (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_c2_vnum), .i_den (w_den), .o_quo (w_qv)
    );

    // Saturate, then align every field with the normal pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px_d[0] <= (w_qx > (POS_QW + 1)'(hvn_pkg::POS_MAX)) ? hvn_pkg::POS_MAX
                                                                  : w_qx[POS_QW-1:0];
            r_pz_d[0] <= (w_qz > (POS_QW + 1)'(hvn_pkg::POS_MAX)) ? hvn_pkg::POS_MAX
                                                                  : w_qz[POS_QW-1:0];
            for (int k = 1; k < POS_DLY; k++) begin
                r_px_d[k] <= r_px_d[k-1];
                r_pz_d[k] <= r_pz_d[k-1];
            end
            r_tu_d[0] <= w_qu;
            r_tv_d[0] <= w_qv;
            for (int k = 1; k < TEX_DLY; k++) begin
                r_tu_d[k] <= r_tu_d[k-1];
                r_tv_d[k] <= r_tv_d[k-1];
            end
            r_py_d[0] <= w_posy;
            for (int k = 1; k < POSY_DLY; k++) begin
                r_py_d[k] <= r_py_d[k-1];
            end
        end
    end

    assign o_pos_x = r_px_d[POS_DLY-1];
    assign o_pos_z = r_pz_d[POS_DLY-1];
    assign o_tex_u = r_tu_d[TEX_DLY-1];
    assign o_tex_v = r_tv_d[TEX_DLY-1];
    assign o_pos_y = r_py_d[POSY_DLY-1];

`ifndef SYNTHESIS
    // An accepted point enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted transaction missing from first stage");

    // Input side only stalls behind a held result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a held result");

    // The y slope is fixed, so the normal always points up and is at most one
    a_ny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_y != '0) && (o_normal_y <= 15'd16384))
        else $error("normal y out of range");

    // Positions saturate at the Q16.8 limit
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_x <= hvn_pkg::POS_MAX) && (o_pos_z <= hvn_pkg::POS_MAX))
        else $error("position above saturation limit");
`endif

endmodule

/* hw/rtl/hvn_div.sv */
// Pipelined restoring divider, one quotient bit per stage, clamps at 2^QW.
module hvn_div #(
    parameter int NW = 35,
    parameter int DW = 10,
    parameter int QW = 24
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW:0]   o_quo
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic          r_ovf [0:QW];

    logic [CW-1:0] n_rem   [1:QW];
    logic [QW-1:0] n_quo   [1:QW];
    logic [CW-1:0] n_trial [1:QW];

    // One trial subtraction per stage, most significant quotient bit first
    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            n_trial[k] = CW'(r_den[k-1]) << (QW - k);
            if (r_rem[k-1] >= n_trial[k]) begin
                n_rem[k] = r_rem[k-1] - n_trial[k];
                n_quo[k] = r_quo[k-1] | (QW'(1) << (QW - k));
            end else begin
                n_rem[k] = r_rem[k-1];
                n_quo[k] = r_quo[k-1];
            end
        end
    end

    // Entry stage flags quotients of 2^QW or more
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << QW);
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= n_quo[k];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, r_quo[QW]};

endmodule

/* hw/rtl/hvn_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module hvn_isqrt #(
    parameter int IW = 64
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_rad,
    output logic [IW/2-1:0] o_root
);

    localparam int RW = IW / 2;
    localparam int MW = RW + 3;

    logic [IW-1:0] r_val  [1:RW];
    logic [MW-1:0] r_rem  [1:RW];
    logic [RW-1:0] r_root [1:RW];

    logic [IW-1:0] c_val   [0:RW-1];
    logic [MW-1:0] c_rem   [0:RW-1];
    logic [RW-1:0] c_root  [0:RW-1];
    logic [MW-1:0] n_sh    [0:RW-1];
    logic [MW-1:0] n_trial [0:RW-1];
    logic [MW-1:0] n_rem   [0:RW-1];
    logic [RW-1:0] n_root  [0:RW-1];

    // Bring down two radicand bits and try root*4+1
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                c_val[k]  = i_rad;
                c_rem[k]  = '0;
                c_root[k] = '0;
            end else begin
                c_val[k]  = r_val[k];
                c_rem[k]  = r_rem[k];
                c_root[k] = r_root[k];
            end
            n_sh[k]    = {c_rem[k][MW-3:0], c_val[k][IW-1 -: 2]};
            n_trial[k] = MW'({c_root[k], 2'b01});
            if (n_sh[k] >= n_trial[k]) begin
                n_rem[k]  = n_sh[k] - n_trial[k];
                n_root[k] = {c_root[k][RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = n_sh[k];
                n_root[k] = {c_root[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= RW; k++) begin
                r_val[k]  <= c_val[k-1] << 2;
                r_rem[k]  <= n_rem[k-1];
                r_root[k] <= n_root[k-1];
            end
        end
    end

    assign o_root = r_root[RW];

endmodule

/* hw/rtl/hvn_height.sv */
// Pixel heights with grid-edge masking, rounded height and slope magnitudes.
module hvn_height #(
    parameter int GW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [GW-1:0]               i_geff,
    input  logic [hvn_pkg::MH_W-1:0]    i_peak_height,
    input  logic [hvn_pkg::IDX_W-1:0]   i_row,
    input  logic [hvn_pkg::IDX_W-1:0]   i_col,
    input  logic [hvn_pkg::PIX_W-1:0]   i_pix [hvn_pkg::PIX_N],
    output logic [hvn_pkg::POSY_W-1:0]  o_pos_y,
    output hvn_pkg::t_slope             o_slope
);

    localparam int XW = (GW > hvn_pkg::GP_W) ? GW : hvn_pkg::GP_W;

    logic [XW-1:0]               w_r, w_c, w_g;
    logic [hvn_pkg::PIX_N-1:0]   w_on;
    logic [15:0]                 r_rg  [hvn_pkg::PIX_N];
    logic [15:0]                 r_bm  [hvn_pkg::PIX_N];
    logic [hvn_pkg::RAW_W-1:0]   r_raw [hvn_pkg::PIX_N];
    logic [hvn_pkg::RAW_W-1:0]   w_rnd [1:hvn_pkg::PIX_N-1];
    logic [hvn_pkg::RAW_W-1:0]   w_hrnd;
    logic [hvn_pkg::SLOPE_W-1:0] r_q   [1:hvn_pkg::PIX_N-1];
    logic [hvn_pkg::POSY_W-1:0]  r_posy3;
    logic [hvn_pkg::POSY_W-1:0]  r_posy4;
    logic [hvn_pkg::SLOPE_W:0]   w_dx, w_dz, w_ndx, w_ndz;
    hvn_pkg::t_slope             r_slope;

    // Which of the five points lie on the grid
    always_comb begin
        w_r = XW'(i_row);
        w_c = XW'(i_col);
        w_g = XW'(i_geff);
        w_on[hvn_pkg::PIX_CTR] = (w_r < w_g) && (w_c < w_g);
        w_on[hvn_pkg::PIX_PR]  = (w_r != '0) && (w_r <= w_g) && (w_c < w_g);
        w_on[hvn_pkg::PIX_NR]  = (w_r + XW'(1) < w_g) && (w_c < w_g);
        w_on[hvn_pkg::PIX_PC]  = (w_c != '0) && (w_c <= w_g) && (w_r < w_g);
        w_on[hvn_pkg::PIX_NC]  = (w_c + XW'(1) < w_g) && (w_r < w_g);
    end

    // Rounding adds for the Q.8 height and the Q.16 neighbor heights
    always_comb begin
        w_hrnd = r_raw[hvn_pkg::PIX_CTR] + 32'd32768;
        for (int p = 1; p < hvn_pkg::PIX_N; p++) begin
            w_rnd[p] = r_raw[p] + 32'd128;
        end
    end

    // Signed slopes split into sign and magnitude
    always_comb begin
        w_dx  = {1'b0, r_q[hvn_pkg::PIX_PR]} - {1'b0, r_q[hvn_pkg::PIX_NR]};
        w_dz  = {1'b0, r_q[hvn_pkg::PIX_NC]} - {1'b0, r_q[hvn_pkg::PIX_PC]};
        w_ndx = '0 - w_dx;
        w_ndz = '0 - w_dz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: R*G (zero off grid) and B*peak height
            for (int p = 0; p < hvn_pkg::PIX_N; p++) begin
                r_rg[p] <= w_on[p] ? 16'(i_pix[p][23:16]) * 16'(i_pix[p][15:8]) : 16'd0;
                r_bm[p] <= 16'(i_pix[p][7:0]) * 16'(i_peak_height);
            end
            // stage 2: full product
            for (int p = 0; p < hvn_pkg::PIX_N; p++) begin
                r_raw[p] <= 32'(r_rg[p]) * 32'(r_bm[p]);
            end
            // stage 3: rounded heights
            r_posy3 <= w_hrnd[31:16];
            for (int p = 1; p < hvn_pkg::PIX_N; p++) begin
                r_q[p] <= w_rnd[p][31:8];
            end
            // stage 4: slopes
            r_posy4       <= r_posy3;
            r_slope.neg_x <= w_dx[hvn_pkg::SLOPE_W];
            r_slope.neg_z <= w_dz[hvn_pkg::SLOPE_W];
            r_slope.mag_x <= w_dx[hvn_pkg::SLOPE_W] ? w_ndx[hvn_pkg::SLOPE_W-1:0]
                                                    : w_dx[hvn_pkg::SLOPE_W-1:0];
            r_slope.mag_z <= w_dz[hvn_pkg::SLOPE_W] ? w_ndz[hvn_pkg::SLOPE_W-1:0]
                                                    : w_dz[hvn_pkg::SLOPE_W-1:0];
        end
    end

    assign o_pos_y = r_posy4;
    assign o_slope = r_slope;

endmodule

/* hw/rtl/hvn_normal.sv */
// Unit normal: sum of squares, pipelined root, three clamped divisions.
module hvn_normal (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  hvn_pkg::t_slope                   i_slope,
    output logic signed [hvn_pkg::NRM_W-1:0]  o_normal_x,
    output logic [hvn_pkg::NRMY_W-1:0]        o_normal_y,
    output logic signed [hvn_pkg::NRM_W-1:0]  o_normal_z
);

    logic [hvn_pkg::SQ_W-1:0]  r_n1_sqx, r_n1_sqz;
    hvn_pkg::t_slope           r_n1_side, r_n2_side;
    logic [hvn_pkg::SUM_W-1:0] w_sum;
    logic [hvn_pkg::RAD_W-1:0] r_n2_rad;
    logic [hvn_pkg::LEN_W-1:0] w_len;
    hvn_pkg::t_slope           r_sd [0:hvn_pkg::SQRT_LAT-1];
    hvn_pkg::t_slope           w_side;
    logic [hvn_pkg::NUM_W-1:0] r_n3_numx, r_n3_numy, r_n3_numz;
    logic [hvn_pkg::LEN_W-1:0] r_n3_len;
    logic [1:0]                r_sg [0:hvn_pkg::NQ_W+1];
    logic [hvn_pkg::NQ_W:0]    w_qx, w_qy, w_qz;
    logic signed [hvn_pkg::NRM_W-1:0] r_nx, r_nz;
    logic [hvn_pkg::NRMY_W-1:0]       r_ny;

    assign w_sum = {2'b00, r_n1_sqx} + {2'b00, r_n1_sqz} + hvn_pkg::Y_SQ;
    assign w_side = r_sd[hvn_pkg::SQRT_LAT-1];

    // Squares, radicand, then numerators with half-length rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1_sqx  <= hvn_pkg::SQ_W'(i_slope.mag_x) * hvn_pkg::SQ_W'(i_slope.mag_x);
            r_n1_sqz  <= hvn_pkg::SQ_W'(i_slope.mag_z) * hvn_pkg::SQ_W'(i_slope.mag_z);
            r_n1_side <= i_slope;
            r_n2_rad  <= hvn_pkg::RAD_W'({w_sum, 12'b0});
            r_n2_side <= r_n1_side;
            r_sd[0]   <= r_n2_side;
            for (int k = 1; k < hvn_pkg::SQRT_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_n3_numx <= hvn_pkg::NUM_W'({w_side.mag_x, 20'b0})
                       + hvn_pkg::NUM_W'(w_len >> 1);
            r_n3_numz <= hvn_pkg::NUM_W'({w_side.mag_z, 20'b0})
                       + hvn_pkg::NUM_W'(w_len >> 1);
            r_n3_numy <= hvn_pkg::Y_NUM + hvn_pkg::NUM_W'(w_len >> 1);
            r_n3_len  <= w_len;
            // signs ride alongside the divider's entry stage and its quotient stages
            r_sg[0]   <= {w_side.neg_x, w_side.neg_z};
            for (int k = 1; k <= hvn_pkg::NQ_W + 1; k++) begin
                r_sg[k] <= r_sg[k-1];
            end
        end
    end

    hvn_isqrt #(.IW(hvn_pkg::RAD_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (r_n2_rad),
        .o_root (w_len)
    );

    hvn_div #(.NW(hvn_pkg::NUM_W), .DW(hvn_pkg::LEN_W), .QW(hvn_pkg::NQ_W)) u_div_x (
        .i_clk (i_clk), .i_en (i_en), .i_num (r_n3_numx), .i_den (r_n3_len), .o_quo (w_qx)
    );

    hvn_div #(.NW(hvn_pkg::NUM_W), .DW(hvn_pkg::LEN_W), .QW(hvn_pkg::NQ_W)) u_div_y (
        .i_clk (i_clk), .i_en (i_en), .i_num (r_n3_numy), .i_den (r_n3_len), .o_quo (w_qy)
    );

    hvn_div #(.NW(hvn_pkg::NUM_W), .DW(hvn_pkg::LEN_W), .QW(hvn_pkg::NQ_W)) u_div_z (
        .i_clk (i_clk), .i_en (i_en), .i_num (r_n3_numz), .i_den (r_n3_len), .o_quo (w_qz)
    );

    // Apply signs; quotients already clamp at one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= r_sg[hvn_pkg::NQ_W+1][1] ? -hvn_pkg::NRM_W'(w_qx)
                                             : hvn_pkg::NRM_W'(w_qx);
            r_nz <= r_sg[hvn_pkg::NQ_W+1][0] ? -hvn_pkg::NRM_W'(w_qz)
                                             : hvn_pkg::NRM_W'(w_qz);
            r_ny <= w_qy;
        end
    end

    assign o_normal_x = r_nx;
    assign o_normal_y = r_ny;
    assign o_normal_z = r_nz;

endmodule

/* test/heightmap_vertex_and_normal_unit_tb.sv */
// Testbench for the heightmap vertex and normal unit: directed and random grid points.
`timescale 1ns / 100ps

module heightmap_vertex_and_normal_unit_tb;

    localparam int MAX_GRID   = 1024;
    localparam int LATENCY    = 55;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [hvn_pkg::POS_W-1:0]  pos_x;
        logic [hvn_pkg::POSY_W-1:0] pos_y;
        logic [hvn_pkg::POS_W-1:0]  pos_z;
        logic [hvn_pkg::NRM_W-1:0]  normal_x;
        logic [hvn_pkg::NRMY_W-1:0] normal_y;
        logic [hvn_pkg::NRM_W-1:0]  normal_z;
        logic [hvn_pkg::TEX_W-1:0]  tex_u;
        logic [hvn_pkg::TEX_W-1:0]  tex_v;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [hvn_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [hvn_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [hvn_pkg::IDX_W-1:0] i_row = '0, i_col = '0;
    logic [hvn_pkg::PIX_W-1:0] i_center_pixel = '0, i_prev_row_pixel = '0;
    logic [hvn_pkg::PIX_W-1:0] i_next_row_pixel = '0;
    logic [hvn_pkg::PIX_W-1:0] i_prev_col_pixel = '0, i_next_col_pixel = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [hvn_pkg::POS_W-1:0] o_pos_x, o_pos_z;
    logic [hvn_pkg::POSY_W-1:0] o_pos_y;
    logic signed [hvn_pkg::NRM_W-1:0] o_normal_x, o_normal_z;
    logic [hvn_pkg::NRMY_W-1:0] o_normal_y;
    logic [hvn_pkg::TEX_W-1:0] o_tex_u, o_tex_v;

    heightmap_vertex_and_normal_unit #(.MAX_GRID(MAX_GRID)) dut (.*);

    // Mirror of the configuration registers
    logic [hvn_pkg::GP_W-1:0]  gp_reg;
    logic [hvn_pkg::EXT_W-1:0] ext_reg;
    logic [hvn_pkg::MH_W-1:0]  mh_reg;

    t_vertex vertex_q[$];
    int  fail_cnt = 0;
    int  idle_cycles = 0;
    bit  rx_quiet = 1'b0;   // no random receiver stalls
    bit  tx_quiet = 1'b0;   // no random sender gaps
    bit  hold_rx = 1'b0;    // long receiver hold-off request

    initial forever #6 i_clk = ~i_clk;

    // Arithmetic helpers
    function automatic longint unsigned div_rnd(longint unsigned num, longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    function automatic longint unsigned clip(longint unsigned v, longint unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // R*G*B*peak height, zero off the grid
    function automatic longint unsigned pixel_height(int r, int c,
                                                     logic [hvn_pkg::PIX_W-1:0] pix, int g);
        if (r < 0 || c < 0 || r >= g || c >= g) return 0;
        return longint'(pix[23:16]) * pix[15:8] * pix[7:0] * mh_reg;
    endfunction

    function automatic logic [hvn_pkg::NRM_W-1:0] unit_comp(bit neg, longint unsigned mag,
                                                             longint unsigned len);
        longint unsigned m;
        m = clip(div_rnd(mag << 20, len), 16384);
        return neg ? hvn_pkg::NRM_W'(17'h10000 - m) : hvn_pkg::NRM_W'(m);
    endfunction

    function automatic t_vertex predict_vertex(int r, int c, logic [hvn_pkg::PIX_W-1:0] pc,
            logic [hvn_pkg::PIX_W-1:0] ppr, logic [hvn_pkg::PIX_W-1:0] pnr,
            logic [hvn_pkg::PIX_W-1:0] ppc, logic [hvn_pkg::PIX_W-1:0] pnc);
        t_vertex v;
        int g;
        longint unsigned den, ext, qpr, qnr, qpc, qnc, ax, az, ay, len;
        bit nxneg, nzneg;
        g = gp_reg;
        if (g < 2) g = 2;
        if (g > MAX_GRID) g = MAX_GRID;
        den = g - 1;
        ext = longint'(ext_reg) << 8;
        v.pos_x = hvn_pkg::POS_W'(clip(div_rnd(c * ext, den), hvn_pkg::POS_MAX));
        v.pos_y = hvn_pkg::POSY_W'(clip(div_rnd(pixel_height(r, c, pc, g), 65536),
                                        16'hFFFF));
        v.pos_z = hvn_pkg::POS_W'(clip(div_rnd(r * ext, den), hvn_pkg::POS_MAX));
        qpr = div_rnd(pixel_height(r - 1, c, ppr, g), 256);
        qnr = div_rnd(pixel_height(r + 1, c, pnr, g), 256);
        qpc = div_rnd(pixel_height(r, c - 1, ppc, g), 256);
        qnc = div_rnd(pixel_height(r, c + 1, pnc, g), 256);
        nxneg = qpr < qnr;
        ax = nxneg ? qnr - qpr : qpr - qnr;
        nzneg = qnc < qpc;
        az = nzneg ? qpc - qnc : qnc - qpc;
        ay = 64'd2 << 16;
        len = int_sqrt((ax * ax + ay * ay + az * az) << 12);
        v.normal_x = unit_comp(nxneg, ax, len);
        v.normal_y = hvn_pkg::NRMY_W'(unit_comp(1'b0, ay, len));
        v.normal_z = unit_comp(nzneg, az, len);
        v.tex_u = hvn_pkg::TEX_W'(clip(div_rnd(longint'(c) << 16, den), 65536));
        v.tex_v = hvn_pkg::TEX_W'(clip(div_rnd(longint'(r) << 16, den), 65536));
        return v;
    endfunction

    // Receiver stall: random, quiet stretches, and the long hold-off
    always @(posedge i_clk) begin
        if (hold_rx) i_stall <= 1'b1;
        else if (rx_quiet) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 7);
    end

    // Result check against the oldest expected vertex
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (vertex_q.size() == 0) begin
                $error("vertex with no expectation");
                fail_cnt++;
            end else begin
                exp_v = vertex_q.pop_front();
                if (o_pos_x !== exp_v.pos_x) begin
                    $error("pos_x exp %0d got %0d", exp_v.pos_x, o_pos_x); fail_cnt++;
                end
                if (o_pos_y !== exp_v.pos_y) begin
                    $error("pos_y exp %0d got %0d", exp_v.pos_y, o_pos_y); fail_cnt++;
                end
                if (o_pos_z !== exp_v.pos_z) begin
                    $error("pos_z exp %0d got %0d", exp_v.pos_z, o_pos_z); fail_cnt++;
                end
                if (o_normal_x !== exp_v.normal_x) begin
                    $error("normal_x exp %h got %h", exp_v.normal_x, o_normal_x); fail_cnt++;
                end
                if (o_normal_y !== exp_v.normal_y) begin
                    $error("normal_y exp %h got %h", exp_v.normal_y, o_normal_y); fail_cnt++;
                end
                if (o_normal_z !== exp_v.normal_z) begin
                    $error("normal_z exp %h got %h", exp_v.normal_z, o_normal_z); fail_cnt++;
                end
                if (o_tex_u !== exp_v.tex_u) begin
                    $error("tex_u exp %0d got %0d", exp_v.tex_u, o_tex_u); fail_cnt++;
                end
                if (o_tex_v !== exp_v.tex_v) begin
                    $error("tex_v exp %0d got %0d", exp_v.tex_v, o_tex_v); fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL heightmap_vertex_and_normal_unit");
            $finish;
        end
    end

    // Send one grid point; the prediction is made on acceptance, valid stays up after
    task automatic send_point(int r, int c, logic [hvn_pkg::PIX_W-1:0] pc,
                              logic [hvn_pkg::PIX_W-1:0] ppr,
                              logic [hvn_pkg::PIX_W-1:0] pnr,
                              logic [hvn_pkg::PIX_W-1:0] ppc,
                              logic [hvn_pkg::PIX_W-1:0] pnc);
        while (!tx_quiet && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_row <= hvn_pkg::IDX_W'(r);
        i_col <= hvn_pkg::IDX_W'(c);
        i_center_pixel <= pc;
        i_prev_row_pixel <= ppr;
        i_next_row_pixel <= pnr;
        i_prev_col_pixel <= ppc;
        i_next_col_pixel <= pnc;
        do @(posedge i_clk); while (o_stall);
        vertex_q.push_back(predict_vertex(r, c, pc, ppr, pnr, ppc, pnc));
    endtask

    task automatic send_random_point(int g);
        int r, c;
        // mostly on the grid and its edges, some anywhere
        if ($urandom_range(9) < 8) begin
            r = $urandom_range(g - 1);
            c = $urandom_range(g - 1);
            if ($urandom_range(5) == 0) r = ($urandom_range(1) != 0) ? 0 : g - 1;
            if ($urandom_range(5) == 0) c = ($urandom_range(1) != 0) ? 0 : g - 1;
        end else begin
            r = $urandom_range(1023);
            c = $urandom_range(1023);
        end
        send_point(r, c, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Drop the input and let every outstanding vertex come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [hvn_pkg::CFG_IDX_W-1:0] idx,
                             logic [hvn_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            hvn_pkg::CFG_GRID_POINTS: gp_reg = data[hvn_pkg::GP_W-1:0];
            hvn_pkg::CFG_GRID_EXTENT: ext_reg = data;
            hvn_pkg::CFG_MAX_HEIGHT:  mh_reg = data[hvn_pkg::MH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int gp, int ext, int mh);
        wait_drained();
        write_reg(hvn_pkg::CFG_GRID_POINTS, hvn_pkg::CFG_DATA_W'(gp));
        write_reg(hvn_pkg::CFG_GRID_EXTENT, hvn_pkg::CFG_DATA_W'(ext));
        write_reg(hvn_pkg::CFG_MAX_HEIGHT, hvn_pkg::CFG_DATA_W'(mh));
        i_cfg_valid <= 1'b0;
    endtask

    // Extremes of pixels and indices at reset settings
    task automatic test_directed();
        send_point(0, 0, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
        send_point(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(1, 1, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
        send_point(1, 1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        send_point(299, 299, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(150, 0, 24'h808080, 24'h010101, 24'hFEFEFE, 24'hAAAAAA, 24'h555555);
        send_point(300, 300, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(1023, 1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(1023, 0, 24'h123456, 24'h654321, 24'hABCDEF, 24'hFEDCBA, 24'h0F0F0F);
        send_point(0, 1023, 24'hF0F0F0, 24'h0F0F0F, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF);
        send_point(298, 10, 24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000);
    endtask

    // Grid size below the minimum, at the ceiling, and zero extent and height
    task automatic test_grid_limits();
        set_config(0, 0, 255);
        send_point(0, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(1, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(2, 5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        set_config(2047, 65535, 0);
        send_point(1023, 1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(512, 0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        set_config(2, 65535, 255);
        send_point(1, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(0, 0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        send_point(700, 3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        set_config(1024, 1, 255);
        send_point(1023, 1022, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    endtask

    // Random points over several settings, with a quiet stretch
    task automatic test_random();
        int gp;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: gp = 2;
                1: gp = 1024;
                2: gp = 300;
                default: gp = $urandom_range(2, 1024);
            endcase
            set_config(gp, (phase == 4) ? 65535 : $urandom_range(1, 65535),
                       (phase == 5) ? 0 : $urandom_range(255));
            rx_quiet = (phase == 3);
            tx_quiet = (phase == 3);
            repeat (60) send_random_point(gp);
        end
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        set_config(300, 1600, 100);
        fork
            begin
                hold_rx = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            repeat (80) send_random_point(300);
        join
    endtask

    initial begin
        gp_reg = hvn_pkg::GP_RESET;
        ext_reg = hvn_pkg::EXT_RESET;
        mh_reg = hvn_pkg::MH_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_grid_limits();
        test_random();
        test_backpressure();
        wait_drained();
        if (fail_cnt == 0) $display("PASS heightmap_vertex_and_normal_unit");
        else $display("FAIL heightmap_vertex_and_normal_unit");
        $finish;
    end

endmodule
